### rtl/core/kts_pkg.sv
package kts_pkg;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// quotient clamp before the final add
	localparam logic [63:0] QUOT_LIMIT = 64'h0000_0100_0000_0000;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         key_slot;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        sample_time;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [5:0]         segment;
		logic               zero_span;
	} result_t;

	typedef struct packed {
		logic               start;
		logic               neg;
		logic [31:0]        a;
		logic [31:0]        b;
		logic [31:0]        d;
		logic signed [31:0] s;
	} lane_req_t;

endpackage

### rtl/core/kts_ram.sv
module kts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/kts_lane.sv
module kts_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  kts_pkg::lane_req_t req,
	output logic               done,
	output logic signed [31:0] res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;
	localparam logic [1:0] PH_FIN  = 2'd3;

	logic [1:0]         phase_q;
	logic [5:0]         cnt_q;
	logic [31:0]        a_q, b_q, d_q;
	logic               neg_q;
	logic signed [31:0] s_q;
	logic [63:0]        dq_q;
	logic [31:0]        rem_q;
	logic               done_q;
	logic signed [31:0] res_q;

	logic [32:0]        trial;
	logic               fits;
	logic [63:0]        qc;
	logic signed [41:0] sum;

	always_comb begin
		trial = {rem_q, dq_q[63]};
		fits  = trial >= {1'b0, d_q};
		qc    = (dq_q > kts_pkg::QUOT_LIMIT) ? kts_pkg::QUOT_LIMIT : dq_q;
		if (neg_q) begin
			sum = 42'(s_q) - $signed({1'b0, qc[40:0]});
		end else begin
			sum = 42'(s_q) + $signed({1'b0, qc[40:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (req.start) phase_q <= PH_MUL;
				end
				PH_MUL: phase_q <= PH_DIV;
				PH_DIV: begin
					if (cnt_q == 6'd63) phase_q <= PH_FIN;
				end
				PH_FIN: begin
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				a_q   <= req.a;
				b_q   <= req.b;
				d_q   <= req.d;
				neg_q <= req.neg;
				s_q   <= req.s;
			end
			PH_MUL: begin
				dq_q  <= 64'(a_q) * 64'(b_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			PH_DIV: begin
				// shift one dividend bit in, one quotient bit out
				if (fits) begin
					rem_q <= 32'(trial - {1'b0, d_q});
				end else begin
					rem_q <= trial[31:0];
				end
				dq_q  <= {dq_q[62:0], fits};
				cnt_q <= cnt_q + 6'd1;
			end
			PH_FIN: begin
				if (sum > 42'sd2147483647) begin
					res_q <= 32'sh7FFF_FFFF;
				end else if (sum < -42'sd2147483648) begin
					res_q <= 32'sh8000_0000;
				end else begin
					res_q <= sum[31:0];
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### rtl/core/keyframe_vec3_track_sampler_unit.sv
// Keyframe track sampler, three components, linear interpolation.
// Item channel: drive item and pulse start; the item is taken on a clock edge
// where start is high and busy is low. A load item (cmd = load) writes the key
// time and x/y/z into slot key_slot and gives no result; a slot
// at or past MAX_KEYS is dropped. A sample item scans the time table from key 0
// and then interpolates the three components in three divider lanes.
// Result channel: done is high for one cycle with result valid; it cannot be
// stalled, and result is marked valid only in that cycle.
// Config channel: cfg_data (key_count) is written on cfg_valid, cfg_ready is
// always high; write it only while busy is low.
// A sample's scan reads the time RAM and then compares, one key after the
// other; each divider lane does a multiply, a serial divide and a finish step.
// A sample landing past the last key, or with one key in use, skips the lanes
// and gives that key itself; a zero-length segment gives its start key.
// One item is in work at a time.
// Reset clears the control state and sets key_count to 1; the key tables are
// not cleared and must be loaded before they are sampled.
module keyframe_vec3_track_sampler_unit #(
	parameter int MAX_KEYS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kts_pkg::item_t   item,
	output logic             done,
	output kts_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [6:0]       cfg_data
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int NW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SRD    = 4'd1;
	localparam logic [3:0] ST_SCMP   = 4'd2;
	localparam logic [3:0] ST_LASTRD = 4'd3;
	localparam logic [3:0] ST_LAST   = 4'd4;
	localparam logic [3:0] ST_SEGRD  = 4'd5;
	localparam logic [3:0] ST_SEGRD2 = 4'd6;
	localparam logic [3:0] ST_SETUP  = 4'd7;
	localparam logic [3:0] ST_WAIT   = 4'd8;

	logic [3:0]    state_q;
	logic [6:0]    key_count_q;
	logic [AW-1:0] i_q;
	logic [NW-1:0] n_q;
	logic [31:0]   t_q, tnext_q, ti_q;
	logic [95:0]   sv_q;

	logic          accept;
	logic          t_we;
	logic [AW-1:0] waddr, t_raddr, v_raddr, i_inc;
	logic [31:0]   t_rd;
	logic [95:0]   v_rd;
	logic [NW-1:0] n_use;
	logic          i_next_last;

	logic signed [32:0] den, num;
	logic signed [32:0] delta [3];
	logic [31:0]        mag_den, mag_num;
	logic               lane_start;
	kts_pkg::lane_req_t lane_req [3];
	logic [2:0]         lane_done;
	logic signed [31:0] lane_res [3];

	logic             done_q;
	kts_pkg::result_t result_q;

	assign accept    = start && !busy;
	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign i_inc     = i_q + AW'(1);

	assign t_we  = accept && item.cmd == kts_pkg::CMD_LOAD && 32'(item.key_slot) < MAX_KEYS;
	assign waddr = AW'(item.key_slot);

	assign t_raddr = (state_q == ST_SRD) ? i_inc : i_q;
	assign v_raddr = (state_q == ST_SEGRD2) ? i_inc : i_q;

	always_comb begin
		if (key_count_q == 7'd0) begin
			n_use = NW'(1);
		end else if (32'(key_count_q) > MAX_KEYS) begin
			n_use = NW'(MAX_KEYS);
		end else begin
			n_use = NW'(key_count_q);
		end
	end

	assign i_next_last = (NW'(i_q) + NW'(2)) == n_q;

	kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(waddr),
		.wdata(item.key_time),
		.raddr(t_raddr),
		.rdata(t_rd)
	);

	kts_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_val_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(waddr),
		.wdata({item.key_x, item.key_y, item.key_z}),
		.raddr(v_raddr),
		.rdata(v_rd)
	);

	always_comb begin
		den        = $signed({1'b0, tnext_q}) - $signed({1'b0, ti_q});
		num        = $signed({1'b0, t_q}) - $signed({1'b0, ti_q});
		mag_den    = den[32] ? 32'(-den) : den[31:0];
		mag_num    = num[32] ? 32'(-num) : num[31:0];
		lane_start = state_q == ST_SETUP && den != '0;
		for (int k = 0; k < 3; k++) begin
			delta[k] = 33'($signed(v_rd[95-32*k -: 32])) - 33'($signed(sv_q[95-32*k -: 32]));
			lane_req[k].start = lane_start;
			lane_req[k].neg   = num[32] ^ delta[k][32] ^ den[32];
			lane_req[k].a     = mag_num;
			lane_req[k].b     = delta[k][32] ? 32'(-delta[k]) : delta[k][31:0];
			lane_req[k].d     = mag_den;
			lane_req[k].s     = $signed(sv_q[95-32*k -: 32]);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		kts_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.req   (lane_req[g]),
			.done  (lane_done[g]),
			.res   (lane_res[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= 7'd1;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) key_count_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == kts_pkg::CMD_SAMPLE) begin
						state_q <= (n_use == NW'(1)) ? ST_LASTRD : ST_SRD;
					end
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (t_rd < t_q) begin
						state_q <= i_next_last ? ST_LASTRD : ST_SRD;
					end else begin
						state_q <= ST_SEGRD;
					end
				end
				ST_LASTRD: state_q <= ST_LAST;
				ST_LAST: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SEGRD:  state_q <= ST_SEGRD2;
				ST_SEGRD2: state_q <= ST_SETUP;
				ST_SETUP: begin
					if (den == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (lane_done[0]) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q <= item.sample_time;
				n_q <= n_use;
				i_q <= '0;
			end
			ST_SCMP: begin
				if (t_rd < t_q) begin
					i_q <= i_inc;
				end else begin
					tnext_q <= t_rd;
				end
			end
			ST_LAST: begin
				result_q.out_x     <= $signed(v_rd[95:64]);
				result_q.out_y     <= $signed(v_rd[63:32]);
				result_q.out_z     <= $signed(v_rd[31:0]);
				result_q.segment   <= 6'(i_q);
				result_q.zero_span <= 1'b0;
			end
			ST_SEGRD2: begin
				ti_q <= t_rd;
				sv_q <= v_rd;
			end
			ST_SETUP: begin
				// zero-length segment: hold the start key
				result_q.out_x     <= $signed(sv_q[95:64]);
				result_q.out_y     <= $signed(sv_q[63:32]);
				result_q.out_z     <= $signed(sv_q[31:0]);
				result_q.segment   <= 6'(i_q);
				result_q.zero_span <= 1'b1;
			end
			ST_WAIT: begin
				result_q.out_x     <= lane_res[0];
				result_q.out_y     <= lane_res[1];
				result_q.out_z     <= lane_res[2];
				result_q.segment   <= 6'(i_q);
				result_q.zero_span <= 1'b0;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without an item in work");

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (lane_done[1] && lane_done[2] && state_q == ST_WAIT))
		else $error("divider lanes out of step");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCMP |-> $past(state_q) == ST_SRD)
		else $error("compare without a time read");

	a_zero_span_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_span) |-> $past(state_q) == ST_SETUP)
		else $error("zero span flag from wrong path");

endmodule

### dv/tb_keyframe_vec3_track_sampler_unit.sv
module tb_keyframe_vec3_track_sampler_unit;

	localparam int N_KEYS = 64;
	localparam int DRAIN_CYCLES = 260;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	kts_pkg::item_t   item;
	logic             done;
	kts_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [6:0]       cfg_data;

	keyframe_vec3_track_sampler_unit #(.MAX_KEYS(N_KEYS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// track model
	logic [31:0] trk_time [N_KEYS];
	logic [31:0] trk_x [N_KEYS];
	logic [31:0] trk_y [N_KEYS];
	logic [31:0] trk_z [N_KEYS];
	logic [6:0]  trk_count;

	kts_pkg::item_t   pending_items [$];
	kts_pkg::result_t sampled_q [$];
	logic    took;
	int      gap_left;
	int      n_sent;
	int      n_fail;
	int      n_samples;
	int      n_zero_span;
	int      n_past_end;

	function automatic void queue_item(kts_pkg::item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	always #4 clk = ~clk;

	function automatic logic [31:0] lerp_lane(logic [31:0] sraw, logic [31:0] eraw,
			longint num, longint den);
		longint s;
		longint delta;
		longint sum;
		logic [127:0] a;
		logic [127:0] b;
		logic [127:0] d;
		logic [127:0] q;
		bit neg;
		s = longint'($signed(sraw));
		delta = longint'($signed(eraw)) - s;
		neg = 1'b0;
		if (num < 0) begin neg = ~neg; a = 128'(-num); end else a = 128'(num);
		if (delta < 0) begin neg = ~neg; b = 128'(-delta); end else b = 128'(delta);
		if (den < 0) begin neg = ~neg; d = 128'(-den); end else d = 128'(den);
		q = (a * b) / d;
		if (q > 128'(kts_pkg::QUOT_LIMIT)) q = 128'(kts_pkg::QUOT_LIMIT);
		sum = neg ? s - longint'(q[63:0]) : s + longint'(q[63:0]);
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	// apply one beat to the track model, return 1 with the sample when one is due
	function automatic bit sample_track(kts_pkg::item_t it, output kts_pkg::result_t r);
		int n;
		int i;
		int nx;
		longint num;
		longint den;
		r = '0;
		if (it.cmd == kts_pkg::CMD_LOAD) begin
			trk_time[it.key_slot] = it.key_time;
			trk_x[it.key_slot] = it.key_x;
			trk_y[it.key_slot] = it.key_y;
			trk_z[it.key_slot] = it.key_z;
			return 1'b0;
		end
		n = trk_count;
		if (n == 0) n = 1;
		if (n > N_KEYS) n = N_KEYS;
		i = 0;
		while (i < n - 1 && trk_time[i + 1] < it.sample_time) i++;
		r.segment = 6'(i);
		if (i == n - 1) begin
			r.out_x = trk_x[i]; r.out_y = trk_y[i]; r.out_z = trk_z[i];
			if (n > 1) n_past_end++;
			return 1'b1;
		end
		nx = i + 1;
		den = longint'(trk_time[nx]) - longint'(trk_time[i]);
		if (den == 0) begin
			r.out_x = trk_x[i]; r.out_y = trk_y[i]; r.out_z = trk_z[i];
			r.zero_span = 1'b1;
			n_zero_span++;
			return 1'b1;
		end
		num = longint'(it.sample_time) - longint'(trk_time[i]);
		r.out_x = lerp_lane(trk_x[i], trk_x[nx], num, den);
		r.out_y = lerp_lane(trk_y[i], trk_y[nx], num, den);
		r.out_z = lerp_lane(trk_z[i], trk_z[nx], num, den);
		return 1'b1;
	endfunction

	// monitor: take beats and check samples at the rising edge
	always @(posedge clk) begin
		kts_pkg::result_t r;
		kts_pkg::result_t want;
		if (arst_n && start && !busy) begin
			if (sample_track(item, r)) begin
				sampled_q.insert(sampled_q.size(), r);
				n_samples++;
			end
			took <= 1'b1;
		end else begin
			took <= 1'b0;
		end
		if (arst_n && done) begin
			if (sampled_q.size() == 0) begin
				$display("%0t: unexpected sample %h", $time, result);
				n_fail++;
			end else begin
				want = sampled_q.pop_front();
				if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
						result.out_z !== want.out_z || result.segment !== want.segment ||
						result.zero_span !== want.zero_span) begin
					$display("%0t: mismatch expected x=%h y=%h z=%h seg=%0d zs=%b",
						$time, want.out_x, want.out_y, want.out_z, want.segment,
						want.zero_span);
					$display("%0t:          actual   x=%h y=%h z=%h seg=%0d zs=%b",
						$time, result.out_x, result.out_y, result.out_z, result.segment,
						result.zero_span);
					n_fail++;
				end
			end
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// driver: change inputs at the falling edge
	always @(negedge clk) begin
		logic next_start;
		bit free;
		next_start = start;
		free = !start || took;
		if (free) begin
			next_start = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() != 0 &&
					!(n_sent == 150 && sampled_q.size() != 0)) begin
				// hold at beat 150 until the sampler has drained
				item <= pending_items.pop_front();
				next_start = 1'b1;
				n_sent++;
				gap_left = pick_gap();
			end
		end
		start <= next_start;
	end

	function automatic kts_pkg::item_t load_beat(int slot, logic [31:0] t, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		kts_pkg::item_t it;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(kts_pkg::item_t)-1:0];
		it.cmd = kts_pkg::CMD_LOAD;
		it.key_slot = 6'(slot);
		it.key_time = t;
		it.key_x = x;
		it.key_y = y;
		it.key_z = z;
		return it;
	endfunction

	function automatic kts_pkg::item_t sample_beat(logic [31:0] t);
		kts_pkg::item_t it;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(kts_pkg::item_t)-1:0];
		it.cmd = kts_pkg::CMD_SAMPLE;
		it.sample_time = t;
		return it;
	endfunction

	function automatic logic [31:0] pick_value();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5) return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		if (p < 6) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return $urandom;
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || start || sampled_q.size() != 0 || busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [6:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		trk_count = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reload n keys, mostly ascending, then a burst of samples and stray loads
	task automatic run_phase(int n, int n_items);
		logic [32:0] t;
		logic [31:0] lo;
		logic [31:0] hi;
		int p;
		t = $urandom_range(0, 3) == 0 ? 33'($urandom) : 33'($urandom_range(0, 32'h0004_0000));
		lo = t[31:0];
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, 19);
			if (p == 0) t = 33'($urandom);
			else if (p > 2) t = t + 33'($urandom_range(1, 32'h0008_0000));
			if (t[32]) t = 33'h0_FFFF_FFFF;
			queue_item(load_beat(k, t[31:0], pick_value(), pick_value(), pick_value()));
		end
		hi = t[31:0];
		for (int k = 0; k < n_items; k++) begin
			p = $urandom_range(0, 19);
			if (p == 0) begin
				queue_item(load_beat($urandom_range(0, 63), $urandom,
					pick_value(), pick_value(), pick_value()));
			end else if (p < 3) begin
				queue_item(sample_beat($urandom));
			end else if (p < 4) begin
				queue_item(sample_beat($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF));
			end else if (p < 6) begin
				queue_item(sample_beat(trk_time[$urandom_range(0, n - 1)]));
			end else begin
				queue_item(sample_beat(hi > lo ? $urandom_range(lo, hi) : lo));
			end
		end
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		n_fail = 0;
		n_samples = 0;
		n_zero_span = 0;
		n_past_end = 0;
		n_sent = 0;
		gap_left = 0;
		took = 1'b0;
		trk_count = 7'd1;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: one key, zero span, extreme deltas, past the end
		queue_item(load_beat(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		queue_item(load_beat(1, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1));
		queue_item(load_beat(2, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_0000));
		queue_item(load_beat(3, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000,
			32'h7FFF_FFFF));
		queue_item(sample_beat(32'h0));
		queue_item(sample_beat(32'hFFFF_FFFF));
		wait_idle();
		write_count(7'd4);
		queue_item(sample_beat(32'h0));
		queue_item(sample_beat(32'h0001_0000));
		queue_item(sample_beat(32'h0001_0001));
		queue_item(sample_beat(32'h0002_0000));
		queue_item(sample_beat(32'h7FFF_FFFF));
		queue_item(sample_beat(32'hFFFF_FFFF));
		// extrapolate before the first key, then a descending segment
		queue_item(load_beat(0, 32'h0002_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF));
		queue_item(load_beat(1, 32'h0004_0000, 32'h7FFF_FFFF, 32'h0000_8000,
			32'h8000_0000));
		queue_item(sample_beat(32'h0));
		queue_item(sample_beat(32'h0003_0000));
		queue_item(load_beat(1, 32'h0000_0100, 32'h0010_0000, 32'hFFF0_0000, 5));
		queue_item(sample_beat(32'h0000_0050));
		queue_item(sample_beat(32'h0000_0000));
		wait_idle();

		// random: fill the whole table first so no unwritten key is read
		run_phase(64, 0);
		write_count(7'd2);   run_phase(2, 50);
		write_count(7'd64);  run_phase(64, 40);
		write_count(7'd0);   run_phase(1, 20);
		write_count(7'd127); run_phase(8, 30);
		write_count(7'd7);   run_phase(7, 50);
		write_count(7'd1);   run_phase(1, 15);
		write_count(7'd33);  run_phase(33, 30);
		write_count(7'd3);   run_phase(3, 50);

		$display("covered %0d beats, %0d samples (%0d zero span, %0d past the last key)",
			n_sent, n_samples, n_zero_span, n_past_end);
		$display("key counts 0, 1, 2, 3, 4, 7, 33, 64 and 127, extremes of all fields");
		if (n_fail == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#12000000;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end

endmodule
